[src/cilc_pkg.sv]
// Shared types, codes and helpers for the C integer literal converter.
package cilc_pkg;

  // Radix codes as reported on the result beat
  localparam logic [1:0] RADIX_DEC    = 2'd0;
  localparam logic [1:0] RADIX_OCT    = 2'd1;
  localparam logic [1:0] RADIX_HEX    = 2'd2;
  localparam logic [1:0] RADIX_UNUSED = 2'd3;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_DIGIT     = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_UP_U  = 8'h55;
  localparam logic [7:0] CH_LO_L  = 8'h6c;
  localparam logic [7:0] CH_UP_L  = 8'h4c;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  localparam int unsigned ValueW = 64;
  localparam int unsigned ResW   = 72;  // 71 bits of fields padded to whole bytes

  // Per-token state carried between characters
  typedef struct packed {
    logic [ValueW-1:0] acc;
    logic [1:0]        radix;
    logic [1:0]        pos;
    logic              first_zero;
    logic              in_suffix;
    logic              uns_seen;
    logic [1:0]        long_seen;
    logic [1:0]        err;
  } tok_t;

  // One result beat
  typedef struct packed {
    logic [1:0]        status;
    logic [1:0]        long_letters;
    logic              unsigned_suffix;
    logic [1:0]        radix;
    logic [ValueW-1:0] value;
  } res_t;

  localparam tok_t TOK_CLEAR = '{acc: '0, radix: RADIX_DEC, pos: 2'd0, first_zero: 1'b0,
                                 in_suffix: 1'b0, uns_seen: 1'b0, long_seen: 2'd0,
                                 err: ST_OK};

  // Hex digit decode: bit 4 is the valid flag, bits 3:0 the digit value
  function automatic logic [4:0] digit_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, 4'(c - CH_ZERO)};
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      r = {1'b1, 4'(c - CH_LO_A + 8'd10)};
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      r = {1'b1, 4'(c - CH_UP_A + 8'd10)};
    end
    return r;
  endfunction

endpackage

[src/cilc_core.sv]
// Token state registers and the per-character update step.
module cilc_core import cilc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,        // a character is processed this cycle
  input  logic [7:0] char_i,
  input  logic       last_i,
  input  logic       limit_mode_i,
  output res_t       res_o
);

  tok_t tok_q, tok_d;

  // Work one character into the token state
  always_comb begin
    tok_t        t;
    logic [1:0]  err1;
    logic [4:0]  dg;
    logic        dig_ok;
    logic [67:0] prod;
    logic [68:0] sum;
    logic [68:0] limit;
    logic        is_x;
    logic [1:0]  status;
    t      = tok_q;
    err1   = ST_OK;
    dg     = digit_of(char_i);
    dig_ok = 1'b0;
    prod   = '0;
    sum    = '0;
    is_x   = (char_i == CH_LO_X) || (char_i == CH_UP_X);
    limit  = limit_mode_i ? {6'd0, 63'h7fff_ffff_ffff_ffff} : {5'd0, 64'hffff_ffff_ffff_ffff};
    status = ST_OK;

    if (char_i == CH_LO_U || char_i == CH_UP_U) begin
      t.in_suffix = 1'b1;
      if (tok_q.uns_seen) begin
        if (tok_q.err == ST_OK) t.err = ST_MALFORMED;
      end else begin
        t.uns_seen = 1'b1;
      end
    end else if (char_i == CH_LO_L || char_i == CH_UP_L) begin
      t.in_suffix = 1'b1;
      if (tok_q.long_seen >= 2'd2) begin
        if (tok_q.err == ST_OK) t.err = ST_MALFORMED;
      end else begin
        t.long_seen = tok_q.long_seen + 2'd1;
      end
    end else begin
      // A suffix letter followed by more characters was a bad digit after all
      err1 = tok_q.err;
      if (tok_q.in_suffix) begin
        if (tok_q.err == ST_OK || tok_q.err == ST_MALFORMED) err1 = ST_DIGIT;
        t.in_suffix = 1'b0;
        t.uns_seen  = 1'b0;
        t.long_seen = 2'd0;
      end
      t.err = err1;
      if (tok_q.pos == 2'd1 && tok_q.first_zero && tok_q.radix == RADIX_OCT && is_x) begin
        t.radix = RADIX_HEX;
      end else begin
        // Scale by the radix with shifts; an unused radix code counts as decimal
        case (tok_q.radix)
          RADIX_HEX: begin
            prod   = {tok_q.acc, 4'd0};
            dig_ok = dg[4];
          end
          RADIX_OCT: begin
            prod   = {1'b0, tok_q.acc, 3'd0};
            dig_ok = dg[4] && (dg[3:0] < 4'd8);
          end
          default: begin
            prod   = {1'b0, tok_q.acc, 3'd0} + {3'd0, tok_q.acc, 1'b0};
            dig_ok = dg[4] && (dg[3:0] < 4'd10);
          end
        endcase
        sum = {1'b0, prod} + {65'd0, dg[3:0]};
        if (err1 == ST_OK) begin
          if (!dig_ok) begin
            t.err = ST_DIGIT;
          end else if (sum > limit) begin
            t.err = ST_RANGE;
          end else begin
            t.acc = sum[ValueW-1:0];
          end
        end
        if (tok_q.pos == 2'd0 && char_i == CH_ZERO) begin
          t.first_zero = 1'b1;
          t.radix      = RADIX_OCT;
        end
      end
      if (tok_q.pos != 2'd3) t.pos = tok_q.pos + 2'd1;
    end

    // Result fields from the updated state
    status = t.err;
    if (status == ST_OK && (t.pos == 2'd0 || (t.radix == RADIX_HEX && t.pos != 2'd3))) begin
      status = ST_MALFORMED;
    end
    res_o.value           = (status == ST_OK) ? t.acc : '0;
    res_o.radix           = (t.radix == RADIX_HEX || t.radix == RADIX_OCT) ? t.radix
                                                                           : RADIX_DEC;
    res_o.unsigned_suffix = t.uns_seen;
    res_o.long_letters    = t.long_seen;
    res_o.status          = status;

    tok_d = last_i ? TOK_CLEAR : t;
  end

  // Hold the token state; clear it after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= TOK_CLEAR;
    end else if (step_i) begin
      tok_q <= tok_d;
    end
  end

endmodule

[src/c_integer_literal_converter_top.sv]
// Top level of the C integer literal converter: input register, core and result register.
//
// Characters of one integer literal token arrive one per beat, with tlast on the final
// character; one result beat follows each token. Each character passes from the input
// register through combinational radix scaling and limit checking into the token state,
// so the block takes one beat per clock while results are drained, and a result is
// registered as its last character is processed. A result waiting on m_axis_tready
// holds the input register, and with it s_axis_tready, until it is taken. The user must
// write the limit mode via the cfg port while no token is in flight; it is not enforced.
module c_integer_literal_converter_top import cilc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // Configuration write
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic            cfg_data_i,      // limit_mode
  // Character stream
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,    // [7:0] char_code
  input  logic            s_axis_tlast,    // last_char
  // Result stream
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [ResW-1:0] m_axis_tdata     // [63:0] value, [65:64] radix,
                                           // [66] unsigned_suffix, [68:67] long_letters,
                                           // [70:69] status, [71] zero
);

  logic       limit_mode_q;
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_last_q;
  logic       advance;
  res_t       res;
  logic       m_valid_q;
  res_t       m_res_q;

  assign cfg_ready_o   = 1'b1;
  assign advance       = in_valid_q && (!m_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_res_q};

  // Hold the limit mode
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_mode_q <= cfg_data_i;
    end
  end

  // Input register: capture a beat, drop it once processed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  cilc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .char_i       (in_char_q),
    .last_i       (in_last_q),
    .limit_mode_i (limit_mode_q),
    .res_o        (res)
  );

  // Result register: load on a last character, release when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (advance) begin
      m_valid_q <= in_last_q;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      m_res_q <= res;
    end
  end

  // A result beat only comes from a processed last character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(advance && in_last_q))
    else $error("result beat without a last character");

  // A stalled result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready) |-> !advance)
    else $error("core advanced over a stalled result");

  // Value is zero whenever status reports an error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_res_q.status != ST_OK) |-> (m_res_q.value == '0))
    else $error("non-zero value on an error result");

  // Radix code three is never reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q |-> (m_res_q.radix != RADIX_UNUSED))
    else $error("unused radix code reported");

endmodule
